FILE: hdl/glyph_row_expander_macros.svh
// assertion macros shared by the glyph row expander
`ifndef GLYPH_ROW_EXPANDER_MACROS_SVH
`define GLYPH_ROW_EXPANDER_MACROS_SVH

// same-cycle implication, checked outside reset
`define GRE_ASSERT_NOW(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("glyph row expander check failed");

// next-cycle implication, checked outside reset
`define GRE_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("glyph row expander check failed");

`endif

FILE: hdl/gre_pkg.sv
// shared constants, types and functions of the glyph row expander
`timescale 1ns / 1ps

package gre_pkg;

    // framebuffer and font geometry
    localparam int LINE_PIXELS = 512;
    localparam int FRAME_BYTES = 557056;
    localparam int MAX_MAGNIFY = 4;
    localparam int GLYPH_COUNT = 256;

    // glyph store and result widths
    localparam int STORE_DEPTH = 2048;
    localparam int STORE_AW    = 11;
    localparam int GLYPH_W     = 8;
    localparam int ADDR_W      = 19;
    localparam int MASK_W      = 32;
    localparam int COLOR_W     = 32;
    localparam int LOAD_AW     = STORE_AW + 1;

    // magnification limit, never beyond what fills the 32-bit masks
    localparam int MAG_LIMIT_INT = (MAX_MAGNIFY < 1) ? 1 :
                                   ((MAX_MAGNIFY > 4) ? 4 : MAX_MAGNIFY);
    localparam logic [2:0] MAG_LIMIT = 3'(MAG_LIMIT_INT);

    // address constants
    localparam logic [ADDR_W-1:0]  BUF1_BASE  = ADDR_W'(FRAME_BYTES / 4);
    localparam logic [ADDR_W-1:0]  LINE_STEP  = ADDR_W'(LINE_PIXELS);
    localparam logic [LOAD_AW-1:0] LOAD_LIMIT = LOAD_AW'(GLYPH_COUNT * 8);

    // request kinds
    localparam logic KIND_DRAW = 1'b0;
    localparam logic KIND_LOAD = 1'b1;

    // draw request handed from the front end to the sequencer
    typedef struct packed {
        logic [7:0]         char_code;
        logic [8:0]         pixel_x;
        logic [8:0]         pixel_y;
        logic [COLOR_W-1:0] fg_color;
        logic [COLOR_W-1:0] bg_color;
        logic               draw_fg;
        logic               draw_bg;
        logic [2:0]         magnify;
    } draw_req_t;

    // character code wrap table
    typedef logic [7:0] char_tab_t [256];

    function automatic char_tab_t build_char_wrap();
        char_tab_t t;
        for (int i = 0; i < 256; i++)
        begin
            t[i] = 8'(i % GLYPH_COUNT);
        end
        return t;
    endfunction

    localparam char_tab_t CHAR_WRAP = build_char_wrap();

    // replicate each font bit mag times, msb leftmost at mask bit 0
    function automatic logic [MASK_W-1:0] expand_row(logic [7:0] bits, logic [2:0] mag);
        logic [MASK_W-1:0] m;
        int                pos;
        m = '0;
        for (int c = 0; c < 8; c++)
        begin
            for (int k = 0; k < 4; k++)
            begin
                pos = c * int'(mag) + k;
                if (k < int'(mag) && bits[7-c] && pos < MASK_W)
                begin
                    m[pos] = 1'b1;
                end
            end
        end
        return m;
    endfunction

    // pixels covered by one output row
    function automatic logic [MASK_W-1:0] span_mask(logic [2:0] mag);
        logic [MASK_W-1:0] s;
        case (mag)
            3'd1:    s = 32'h0000_00FF;
            3'd2:    s = 32'h0000_FFFF;
            3'd3:    s = 32'h00FF_FFFF;
            default: s = 32'hFFFF_FFFF;
        endcase
        return s;
    endfunction

endpackage

FILE: hdl/gre_ram.sv
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps

module gre_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/gre_seq.sv
// draw sequencer: fetches glyph rows and emits magnified output rows
`timescale 1ns / 1ps

module gre_seq (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  gre_pkg::draw_req_t                  req,
    input  logic                                draw_buffer,
    output logic                                busy,
    output logic                                rd_en,
    output logic [gre_pkg::STORE_AW-1:0]        rd_addr,
    input  logic [gre_pkg::GLYPH_W-1:0]         rd_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [gre_pkg::ADDR_W-1:0]          row_address,
    output logic [gre_pkg::MASK_W-1:0]          fg_mask,
    output logic [gre_pkg::MASK_W-1:0]          write_mask,
    output logic [gre_pkg::COLOR_W-1:0]         out_fg_color,
    output logic [gre_pkg::COLOR_W-1:0]         out_bg_color,
    output logic                                last_row
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_FETCH = 2'd1;
    localparam logic [1:0] ST_EMIT  = 2'd2;

    // control state
    logic [1:0] state_reg, state_next;
    logic [2:0] gr_reg, gr_next;
    logic [1:0] rep_reg, rep_next;
    logic       out_valid_reg, out_valid_next;

    // draw context
    logic [2:0]                   mag_reg, mag_next;
    logic [7:0]                   gbase_reg, gbase_next;
    logic [gre_pkg::GLYPH_W-1:0]  bits_reg, bits_next;
    logic [gre_pkg::ADDR_W-1:0]   addr_reg, addr_next;
    logic [gre_pkg::COLOR_W-1:0]  fg_reg, fg_next;
    logic [gre_pkg::COLOR_W-1:0]  bg_reg, bg_next;
    logic                         dfg_reg, dfg_next;
    logic                         dbg_reg, dbg_next;

    // output register
    logic [gre_pkg::ADDR_W-1:0]   oaddr_reg, oaddr_next;
    logic [gre_pkg::MASK_W-1:0]   ofm_reg, ofm_next;
    logic [gre_pkg::MASK_W-1:0]   owm_reg, owm_next;
    logic [gre_pkg::COLOR_W-1:0]  ofg_reg, ofg_next;
    logic [gre_pkg::COLOR_W-1:0]  obg_reg, obg_next;
    logic                         olast_reg, olast_next;

    // per-row helpers
    logic [2:0]                  mag_clamp;
    logic [gre_pkg::ADDR_W-1:0]  start_addr;
    logic [gre_pkg::MASK_W-1:0]  row_fm;
    logic [gre_pkg::MASK_W-1:0]  row_wm;
    logic                        rep_last;
    logic                        emit;

    // magnification clamp and first row address of a new request
    always_comb
    begin
        mag_clamp = req.magnify;
        if (req.magnify == 3'd0)
        begin
            mag_clamp = 3'd1;
        end
        else if (req.magnify > gre_pkg::MAG_LIMIT)
        begin
            mag_clamp = gre_pkg::MAG_LIMIT;
        end
        start_addr = (draw_buffer ? gre_pkg::BUF1_BASE : '0)
                   + gre_pkg::ADDR_W'(req.pixel_y) * gre_pkg::LINE_STEP
                   + gre_pkg::ADDR_W'(req.pixel_x);
    end

    // masks of the current glyph row
    always_comb
    begin
        row_fm = gre_pkg::expand_row(bits_reg, mag_reg);
        row_wm = (dfg_reg ? row_fm : '0)
               | (dbg_reg ? (~row_fm & gre_pkg::span_mask(mag_reg)) : '0);
    end

    assign rep_last = ({1'b0, rep_reg} == (mag_reg - 3'd1));
    assign emit     = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        gr_next        = gr_reg;
        rep_next       = rep_reg;
        mag_next       = mag_reg;
        gbase_next     = gbase_reg;
        bits_next      = bits_reg;
        addr_next      = addr_reg;
        fg_next        = fg_reg;
        bg_next        = bg_reg;
        dfg_next       = dfg_reg;
        dbg_next       = dbg_reg;
        rd_en          = 1'b0;
        rd_addr        = {gbase_reg, gr_reg};
        out_valid_next = out_valid_reg && !out_ready;
        oaddr_next     = oaddr_reg;
        ofm_next       = ofm_reg;
        owm_next       = owm_reg;
        ofg_next       = ofg_reg;
        obg_next       = obg_reg;
        olast_next     = olast_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    mag_next   = mag_clamp;
                    gbase_next = gre_pkg::CHAR_WRAP[req.char_code];
                    addr_next  = start_addr;
                    fg_next    = req.fg_color;
                    bg_next    = req.bg_color;
                    dfg_next   = req.draw_fg;
                    dbg_next   = req.draw_bg;
                    gr_next    = 3'd0;
                    rep_next   = 2'd0;
                    rd_en      = 1'b1;
                    rd_addr    = {gre_pkg::CHAR_WRAP[req.char_code], 3'd0};
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                // first row arrives, prefetch the second
                bits_next  = rd_data;
                rd_en      = 1'b1;
                rd_addr    = {gbase_reg, 3'd1};
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (emit)
                begin
                    out_valid_next = 1'b1;
                    oaddr_next     = addr_reg;
                    ofm_next       = row_fm;
                    owm_next       = row_wm;
                    ofg_next       = fg_reg;
                    obg_next       = bg_reg;
                    olast_next     = rep_last && (gr_reg == 3'd7);
                    addr_next      = addr_reg + gre_pkg::LINE_STEP;
                    rep_next       = rep_reg + 2'd1;
                    if (rep_last)
                    begin
                        rep_next = 2'd0;
                        if (gr_reg == 3'd7)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            // take the prefetched row, fetch the one after
                            bits_next = rd_data;
                            gr_next   = gr_reg + 3'd1;
                            rd_en     = (gr_reg != 3'd6);
                            rd_addr   = {gbase_reg, 3'(gr_reg + 3'd2)};
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            gr_reg        <= 3'd0;
            rep_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            gr_reg        <= gr_next;
            rep_reg       <= rep_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        mag_reg   <= mag_next;
        gbase_reg <= gbase_next;
        bits_reg  <= bits_next;
        addr_reg  <= addr_next;
        fg_reg    <= fg_next;
        bg_reg    <= bg_next;
        dfg_reg   <= dfg_next;
        dbg_reg   <= dbg_next;
        oaddr_reg <= oaddr_next;
        ofm_reg   <= ofm_next;
        owm_reg   <= owm_next;
        ofg_reg   <= ofg_next;
        obg_reg   <= obg_next;
        olast_reg <= olast_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign row_address  = oaddr_reg;
    assign fg_mask      = ofm_reg;
    assign write_mask   = owm_reg;
    assign out_fg_color = ofg_reg;
    assign out_bg_color = obg_reg;
    assign last_row     = olast_reg;

endmodule

FILE: hdl/glyph_row_expander.sv
// glyph_row_expander: top level of the 8x8 bitmap font character generator.
// A load request writes one font byte into the 2048-byte glyph store. A draw
// request first issues the first glyph store read, then takes its data, then
// gives one output row per cycle while the output side does not stall, with
// the next glyph row fetched while the current one is repeated. The glyph
// store has a single read port and the sequencer a single output register. A
// new request is taken as soon as the last row of a character sits in the
// output register. The glyph store has no reset; drawing a glyph row that was
// never loaded gives undefined masks.
`timescale 1ns / 1ps

`include "glyph_row_expander_macros.svh"

module glyph_row_expander (
    input  logic                                clk,
    input  logic                                rst_n,
    // request channel
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                kind,
    input  logic [7:0]                          char_code,
    input  logic [8:0]                          pixel_x,
    input  logic [8:0]                          pixel_y,
    input  logic [gre_pkg::COLOR_W-1:0]         fg_color,
    input  logic [gre_pkg::COLOR_W-1:0]         bg_color,
    input  logic                                draw_fg,
    input  logic                                draw_bg,
    input  logic [2:0]                          magnify,
    input  logic [gre_pkg::STORE_AW-1:0]        font_index,
    input  logic [gre_pkg::GLYPH_W-1:0]         font_byte,
    // result channel
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [gre_pkg::ADDR_W-1:0]          row_address,
    output logic [gre_pkg::MASK_W-1:0]          fg_mask,
    output logic [gre_pkg::MASK_W-1:0]          write_mask,
    output logic [gre_pkg::COLOR_W-1:0]         out_fg_color,
    output logic [gre_pkg::COLOR_W-1:0]         out_bg_color,
    output logic                                last_row,
    // configuration channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic                                draw_buffer
);

    logic                                draw_buffer_reg;
    logic                                seq_busy;
    logic                                in_take;
    logic                                draw_start;
    logic                                ram_we;
    logic                                ram_re;
    logic [gre_pkg::STORE_AW-1:0]        ram_raddr;
    logic [gre_pkg::GLYPH_W-1:0]         ram_rdata;
    gre_pkg::draw_req_t                  req;

    // request decode
    assign in_ready   = !seq_busy;
    assign in_take    = in_valid && in_ready;
    assign draw_start = in_take && (kind == gre_pkg::KIND_DRAW);
    assign ram_we     = in_take && (kind == gre_pkg::KIND_LOAD)
                     && ({1'b0, font_index} < gre_pkg::LOAD_LIMIT);

    // draw request bundle
    always_comb
    begin
        req.char_code = char_code;
        req.pixel_x   = pixel_x;
        req.pixel_y   = pixel_y;
        req.fg_color  = fg_color;
        req.bg_color  = bg_color;
        req.draw_fg   = draw_fg;
        req.draw_bg   = draw_bg;
        req.magnify   = magnify;
    end

    // draw buffer select register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            draw_buffer_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            draw_buffer_reg <= draw_buffer;
        end
    end

    // glyph store
    gre_ram #(
        .WIDTH (gre_pkg::GLYPH_W),
        .DEPTH (gre_pkg::STORE_DEPTH)
    ) u_glyph_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (font_index),
        .wdata (font_byte),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // row sequencer
    gre_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (draw_start),
        .req          (req),
        .draw_buffer  (draw_buffer_reg),
        .busy         (seq_busy),
        .rd_en        (ram_re),
        .rd_addr      (ram_raddr),
        .rd_data      (ram_rdata),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .row_address  (row_address),
        .fg_mask      (fg_mask),
        .write_mask   (write_mask),
        .out_fg_color (out_fg_color),
        .out_bg_color (out_bg_color),
        .last_row     (last_row)
    );

    // checks
    `GRE_ASSERT_NEXT(a_out_held, clk, rst_n, out_valid && !out_ready, out_valid && $stable(fg_mask))
    `GRE_ASSERT_NEXT(a_draw_holds_input, clk, rst_n, draw_start, !in_ready)
    `GRE_ASSERT_NOW(a_load_only_between_draws, clk, rst_n, ram_we, !seq_busy && !ram_re)

endmodule
